[hw/rtl/http_body_chunked_decoder_macros.svh]
// ---------------------------------------------------------------------------
// HTTP body decoder assertion macros
// Shared concurrent assertion forms, reset-qualified.
// ---------------------------------------------------------------------------
`ifndef HTTP_BODY_CHUNKED_DECODER_MACROS_SVH
`define HTTP_BODY_CHUNKED_DECODER_MACROS_SVH

// same-cycle implication
`define HBCD_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HBCD_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/hbcd_pkg.sv]
// ---------------------------------------------------------------------------
// HTTP body decoder package
// Status codes, register indexes, character constants and hex decode.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hbcd_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 32;
  localparam int unsigned CFG_W           = 32;
  localparam int unsigned CFG_INDEX_W     = 2;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [CFG_W-1:0]       cfg_data_t;
  typedef logic [7:0]             byte_t;

  typedef enum logic [1:0] {
    ST_PENDING = 2'd0,
    ST_OK      = 2'd1,
    ST_BAD     = 2'd2,
    ST_LARGE   = 2'd3
  } status_t;

  localparam cfg_index_t CFG_CHUNKED_MODE  = 2'd0;
  localparam cfg_index_t CFG_CONTENT_LEN   = 2'd1;
  localparam cfg_index_t CFG_MAX_BODY_SIZE = 2'd2;

  localparam cfg_data_t MAX_BODY_RESET = 32'd4096;

  localparam byte_t CH_CR = 8'h0d;
  localparam byte_t CH_LF = 8'h0a;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input byte_t c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= "0" && c <= "9") begin
      h.val = 4'(c - "0");
    end else if (c >= "a" && c <= "f") begin
      h.val = 4'(c - "a" + 8'd10);
    end else if (c >= "A" && c <= "F") begin
      h.val = 4'(c - "A" + 8'd10);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/http_body_chunked_decoder.sv]
// ---------------------------------------------------------------------------
// HTTP body chunked decoder
// Per-byte body framing: fixed length or chunked transfer, with status.
// ---------------------------------------------------------------------------
//  channel | signals                                   | direction
//  in      | in_valid/in_ready, data_byte, start_of_message | byte stream in
//  out     | out_valid/out_ready, payload_*, status    | one word per byte
//  cfg     | cfg_we, cfg_index, cfg_data               | register write
//
// One byte per cycle sustained while the result is not stalled; an accepted
// byte passes the input register, then the result register. Decoding compares
// against the limits plus a counter update. Reset clears decoder state and
// loads register defaults; no clearing pass. A stalled result holds the
// input register, which in turn drops in_ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "http_body_chunked_decoder_macros.svh"

module http_body_chunked_decoder #(
  parameter int unsigned COUNT_WIDTH = hbcd_pkg::COUNT_WIDTH_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  hbcd_pkg::byte_t      data_byte,
  input  wire                  start_of_message,
  output logic                 out_valid,
  input  wire                  out_ready,
  output hbcd_pkg::byte_t      payload_byte,
  output logic                 payload_valid,
  output hbcd_pkg::status_t    parse_status,
  input  wire                  cfg_we,
  input  hbcd_pkg::cfg_index_t cfg_index,
  input  hbcd_pkg::cfg_data_t  cfg_data
);
  import hbcd_pkg::*;

  localparam int unsigned CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

  // configuration
  logic      chunked_mode;
  cfg_data_t content_length;
  cfg_data_t max_body_size;

  // input register
  logic  s1_valid;
  byte_t s1_byte;
  logic  s1_sof;
  logic  advance;

  // decoder state
  logic                   in_size_line, in_size_line_next;
  logic                   cr_seen, cr_seen_next;
  logic                   last_chunk, last_chunk_next;
  logic [COUNT_WIDTH-1:0] remaining_count, remaining_count_next;
  logic [COUNT_WIDTH-1:0] body_count, body_count_next;
  status_t                final_status, final_status_next;

  // step results
  logic    fwd;
  status_t st;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunked_mode   <= 1'b0;
      content_length <= '0;
      max_body_size  <= MAX_BODY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHUNKED_MODE:  chunked_mode   <= cfg_data[0];
        CFG_CONTENT_LEN:   content_length <= cfg_data;
        CFG_MAX_BODY_SIZE: max_body_size  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= data_byte;
      s1_sof  <= start_of_message;
    end
  end

  always_comb begin
    logic                   c_in_size;
    logic                   c_cr;
    logic                   c_last;
    logic [COUNT_WIDTH-1:0] c_rem;
    logic [COUNT_WIDTH-1:0] c_body;
    status_t                c_final;
    logic [COUNT_WIDTH-1:0] body_inc;
    logic [CMP_W-1:0]       body_ext;
    logic [CMP_W-1:0]       inc_ext;
    logic [CMP_W-1:0]       cl_ext;
    logic [CMP_W-1:0]       max_ext;
    hex_t                   hx;

    // start of message clears state ahead of this byte
    c_in_size = s1_sof ? 1'b1 : in_size_line;
    c_cr      = s1_sof ? 1'b0 : cr_seen;
    c_last    = s1_sof ? 1'b0 : last_chunk;
    c_rem     = s1_sof ? '0 : remaining_count;
    c_body    = s1_sof ? '0 : body_count;
    c_final   = s1_sof ? ST_PENDING : final_status;

    body_inc = (c_body != '1) ? c_body + COUNT_WIDTH'(1) : c_body;
    body_ext = CMP_W'(c_body);
    inc_ext  = CMP_W'(body_inc);
    cl_ext   = CMP_W'(content_length);
    max_ext  = CMP_W'(max_body_size);
    hx       = hex_decode(s1_byte);

    in_size_line_next    = c_in_size;
    cr_seen_next         = c_cr;
    last_chunk_next      = c_last;
    remaining_count_next = c_rem;
    body_count_next      = c_body;
    final_status_next    = c_final;
    fwd                  = 1'b0;
    st                   = ST_PENDING;

    if (c_final != ST_PENDING) begin
      st = c_final;
    end else if (!chunked_mode) begin
      // overrun is checked before the size limit
      if (body_ext >= cl_ext) begin
        st = ST_BAD;
      end else if (body_ext >= max_ext) begin
        st = ST_LARGE;
      end else begin
        fwd             = 1'b1;
        body_count_next = body_inc;
        if (inc_ext == cl_ext) begin
          st = ST_OK;
        end
      end
      final_status_next = st;
    end else if (c_in_size) begin
      if (s1_byte == CH_CR) begin
        cr_seen_next = 1'b1;
      end else if (c_cr && s1_byte == CH_LF) begin
        in_size_line_next = 1'b0;
        cr_seen_next      = 1'b0;
        if (c_rem == '0) begin
          last_chunk_next = 1'b1;
        end
      end else if (hx.ok) begin
        // another digit would overflow the counter
        if (c_rem[COUNT_WIDTH-1 -: 4] != 4'd0) begin
          st = ST_BAD;
        end else begin
          remaining_count_next = {c_rem[COUNT_WIDTH-5:0], hx.val};
          cr_seen_next         = 1'b0;
        end
      end else begin
        st = ST_BAD;
      end
      final_status_next = st;
    end else begin
      if (c_rem != '0) begin
        if (body_ext >= max_ext) begin
          st = ST_LARGE;
        end else begin
          fwd                  = 1'b1;
          body_count_next      = body_inc;
          remaining_count_next = c_rem - COUNT_WIDTH'(1);
          cr_seen_next         = 1'b0;
        end
      end else if (s1_byte == CH_CR) begin
        cr_seen_next = 1'b1;
      end else if (c_cr && s1_byte == CH_LF) begin
        in_size_line_next = 1'b1;
        cr_seen_next      = 1'b0;
        if (c_last) begin
          st = ST_OK;
        end
      end else begin
        st = ST_BAD;
      end
      final_status_next = st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_size_line    <= 1'b1;
      cr_seen         <= 1'b0;
      last_chunk      <= 1'b0;
      remaining_count <= '0;
      body_count      <= '0;
      final_status    <= ST_PENDING;
    end else if (advance) begin
      in_size_line    <= in_size_line_next;
      cr_seen         <= cr_seen_next;
      last_chunk      <= last_chunk_next;
      remaining_count <= remaining_count_next;
      body_count      <= body_count_next;
      final_status    <= final_status_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      payload_byte  <= fwd ? s1_byte : '0;
      payload_valid <= fwd;
      parse_status  <= st;
    end
  end

  `HBCD_ASSERT_IMPL(a_fwd_status, clk, rst, out_valid && payload_valid, parse_status == ST_PENDING || parse_status == ST_OK, "payload word with error status")
  `HBCD_ASSERT_NEXT(a_held_final, clk, rst, advance && !s1_sof && final_status != ST_PENDING, out_valid && !payload_valid && parse_status == $past(final_status), "byte after final status not ignored")
  `HBCD_ASSERT_IMPL(a_last_no_rem, clk, rst, last_chunk && final_status == ST_PENDING, remaining_count == '0, "data remaining after last chunk")
  `HBCD_ASSERT_NEXT(a_count_mono, clk, rst, advance && !s1_sof, body_count >= $past(body_count), "body count went backwards")

endmodule

`default_nettype wire
